// ===== rtl/core/hts_pkg.sv =====
// shared constants, types and helpers of the html text extractor
package hts_pkg;

  localparam int unsigned LimitW             = 23;
  localparam logic [LimitW-1:0] LimitReset   = 23'd5242879;
  localparam int unsigned WindowBytesDefault = 9;
  localparam int unsigned MatchBytes         = 9;
  localparam int unsigned SkipW              = 4;
  localparam int unsigned PatLenW            = 4;

  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChNl    = 8'h0A;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChLt    = 8'h3C;
  localparam logic [7:0] ChGt    = 8'h3E;

  // byte 0 of each pattern sits in the low bits
  localparam logic [8*MatchBytes-1:0] PatScriptOpen  = "tpircs<";
  localparam logic [8*MatchBytes-1:0] PatScriptClose = ">tpircs/<";
  localparam logic [8*MatchBytes-1:0] PatStyleOpen   = "elyts<";
  localparam logic [8*MatchBytes-1:0] PatStyleClose  = ">elyts/<";

  localparam logic [PatLenW-1:0] LenScriptOpen  = 4'd7;
  localparam logic [PatLenW-1:0] LenScriptClose = 4'd9;
  localparam logic [PatLenW-1:0] LenStyleOpen   = 4'd6;
  localparam logic [PatLenW-1:0] LenStyleClose  = 4'd8;

  // closer bytes left to consume after its first byte
  localparam logic [SkipW-1:0] SkipScript = 4'd8;
  localparam logic [SkipW-1:0] SkipStyle  = 4'd7;

  typedef struct packed {
    logic step;
    logic clear;
  } hts_ctl_t;

  typedef struct packed {
    logic       emit;
    logic [7:0] data;
  } hts_res_t;

  function automatic logic [7:0] fold(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c inside {[8'h41:8'h5A]}) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

  function automatic logic pat_match(input logic [8*MatchBytes-1:0] look,
                                     input logic [MatchBytes-1:0]   vld,
                                     input logic [8*MatchBytes-1:0] pat,
                                     input logic [PatLenW-1:0]      len);
    logic hit;
    hit = 1'b1;
    for (int i = 0; i < MatchBytes; i++) begin
      if (PatLenW'(i) < len) begin
        if (!vld[i] || fold(look[8*i +: 8]) != pat[8*i +: 8]) begin
          hit = 1'b0;
        end
      end
    end
    return hit;
  endfunction

endpackage

// ===== rtl/core/hts_cell.sv =====
// one byte cell of the lookahead chain
module hts_cell (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       shift_i,
  input  logic [7:0] byte_i,
  input  logic       vld_i,
  output logic [7:0] byte_o,
  output logic       vld_o
);

  logic [7:0] byte_q;
  logic       vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (shift_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      byte_q <= byte_i;
    end
  end

  assign byte_o = byte_q;
  assign vld_o  = vld_q;

endmodule

// ===== rtl/core/hts_judge.sv =====
// head byte decision and per-document text state
module hts_judge import hts_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  hts_ctl_t                ctl_i,
  input  logic [8*MatchBytes-1:0] look_i,
  input  logic [MatchBytes-1:0]   look_vld_i,
  input  logic [LimitW-1:0]       limit_i,
  output hts_res_t                res_o
);

  logic [SkipW-1:0]  skip_q, skip_d;
  logic              tag_q, tag_d;
  logic              script_q, script_d;
  logic              style_q, style_d;
  logic [7:0]        prev_q, prev_d;
  logic [LimitW-1:0] count_q, count_d;
  logic              ended_q, ended_d;

  logic [7:0] head;
  logic       m_so, m_sc, m_sto, m_stc, closer;

  assign head   = look_i[7:0];
  assign m_so   = pat_match(look_i, look_vld_i, PatScriptOpen, LenScriptOpen);
  assign m_sc   = pat_match(look_i, look_vld_i, PatScriptClose, LenScriptClose);
  assign m_sto  = pat_match(look_i, look_vld_i, PatStyleOpen, LenStyleOpen);
  assign m_stc  = pat_match(look_i, look_vld_i, PatStyleClose, LenStyleClose);
  assign closer = !m_so && (m_sc || (!m_sto && m_stc));

  always_comb begin
    skip_d   = skip_q;
    tag_d    = tag_q;
    script_d = script_q;
    style_d  = style_q;
    prev_d   = prev_q;
    count_d  = count_q;
    ended_d  = ended_q;
    res_o    = '0;
    if (!ended_q) begin
      if (skip_q != '0) begin
        skip_d = skip_q - 1'b1;
      end else if (count_q >= limit_i || head == ChNul) begin
        ended_d = 1'b1;
      end else begin
        if (m_so) begin
          script_d = 1'b1;
          tag_d    = 1'b1;
        end else if (m_sc) begin
          script_d = 1'b0;
          tag_d    = 1'b0;
          skip_d   = SkipScript;
        end else if (m_sto) begin
          style_d = 1'b1;
          tag_d   = 1'b1;
        end else if (m_stc) begin
          style_d = 1'b0;
          tag_d   = 1'b0;
          skip_d  = SkipStyle;
        end
        if (!closer && !(script_d || style_d)) begin
          if (head == ChLt) begin
            tag_d = 1'b1;
          end else if (head == ChGt) begin
            tag_d = 1'b0;
            if (count_q != '0 && prev_q != ChSpace && prev_q != ChNl) begin
              res_o.emit = 1'b1;
              res_o.data = ChSpace;
            end
          end else if (!tag_d) begin
            res_o.emit = 1'b1;
            res_o.data = head;
          end
        end
      end
    end
    if (res_o.emit) begin
      count_d = count_q + 1'b1;
      prev_d  = res_o.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_q   <= '0;
      tag_q    <= 1'b0;
      script_q <= 1'b0;
      style_q  <= 1'b0;
      prev_q   <= '0;
      count_q  <= '0;
      ended_q  <= 1'b0;
    end else if (ctl_i.clear) begin
      skip_q   <= '0;
      tag_q    <= 1'b0;
      script_q <= 1'b0;
      style_q  <= 1'b0;
      prev_q   <= '0;
      count_q  <= '0;
      ended_q  <= 1'b0;
    end else if (ctl_i.step) begin
      skip_q   <= skip_d;
      tag_q    <= tag_d;
      script_q <= script_d;
      style_q  <= style_d;
      prev_q   <= prev_d;
      count_q  <= count_d;
      ended_q  <= ended_d;
    end
  end

endmodule

// ===== rtl/core/html_tag_stripper.sv =====
// top level: byte chain, head decision, output stage and limit register
//
//   channel   dir  handshake            payload
//   s_axis    in   tvalid/tready        tdata = in_byte, tlast = in_last
//   m_axis    out  tvalid/tready        tdata = out_byte, tuser = has_byte,
//                                       tlast = out_last
//   apb       in   psel/penable/pready  0x0: output_limit (23 bits)
//
// one byte per cycle enters the chain while no drain runs and the chain can move; once full, each new byte pushes the
// oldest byte into the head decision, which gives at most one result per cycle.
// a request with tlast set starts a drain in which no request is taken; the chain shifts out its
// remaining bytes and, once it is empty, the final result is put out.
// a full chain only moves when the output register is free or being taken.
// reset empties the chain and clears the document state; output_limit resets to 5242879.
module html_tag_stripper import hts_pkg::*; #(
  parameter int unsigned WindowBytes = WindowBytesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // in_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // out_byte
  output logic        m_axis_tuser,   // has_byte
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic RegIdxLimit = 1'b0;

  logic [WindowBytes-1:0][7:0] cell_byte;
  logic [WindowBytes-1:0]      cell_vld;
  logic [WindowBytes-1:0][7:0] nxt_byte;
  logic [WindowBytes-1:0]      nxt_vld;

  hts_ctl_t jctl;
  hts_res_t jres;

  logic can_out, full, any_vld, accept, shift, finish, emit, out_load;

  logic              drain_q, drain_d;
  logic              hold_vld_q, hold_vld_d;
  logic [7:0]        hold_data_q;
  logic              out_vld_q, out_vld_d;
  logic [7:0]        out_data_q;
  logic              out_user_q, out_last_q;
  logic [LimitW-1:0] limit_q;

  // lookahead chain, cell 0 is the head
  for (genvar i = 0; i < WindowBytes; i++) begin : g_cell
    if (i == WindowBytes - 1) begin : g_tail
      assign nxt_byte[i] = s_axis_tdata;
      assign nxt_vld[i]  = accept;
    end else begin : g_mid
      assign nxt_byte[i] = cell_byte[i+1];
      assign nxt_vld[i]  = cell_vld[i+1];
    end
    hts_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift),
      .byte_i  (nxt_byte[i]),
      .vld_i   (nxt_vld[i]),
      .byte_o  (cell_byte[i]),
      .vld_o   (cell_vld[i])
    );
  end

  hts_judge u_judge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (jctl),
    .look_i     (cell_byte[MatchBytes-1:0]),
    .look_vld_i (cell_vld[MatchBytes-1:0]),
    .limit_i    (limit_q),
    .res_o      (jres)
  );

  assign can_out       = !out_vld_q || m_axis_tready;
  assign full          = &cell_vld;
  assign any_vld       = |cell_vld;
  assign s_axis_tready = !drain_q && (!full || can_out);
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    jctl   = '0;
    shift  = 1'b0;
    finish = 1'b0;
    if (!drain_q) begin
      jctl.step = full && accept;
      shift     = accept || jctl.step;
    end else if (can_out) begin
      if (any_vld) begin
        shift     = 1'b1;
        jctl.step = cell_vld[0];
      end else begin
        finish = 1'b1;
      end
    end
    jctl.clear = finish;
  end

  assign emit     = jctl.step && jres.emit;
  // while draining, one result is held back until it is known whether it is the final one
  assign out_load = (emit && (!drain_q || hold_vld_q)) || finish;

  always_comb begin
    drain_d    = drain_q;
    hold_vld_d = hold_vld_q;
    out_vld_d  = out_vld_q;
    if (accept && s_axis_tlast) begin
      drain_d = 1'b1;
    end else if (finish) begin
      drain_d = 1'b0;
    end
    if (finish) begin
      hold_vld_d = 1'b0;
    end else if (drain_q && emit) begin
      hold_vld_d = 1'b1;
    end
    if (out_load) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drain_q    <= 1'b0;
      hold_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      drain_q    <= drain_d;
      hold_vld_q <= hold_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (drain_q && emit) begin
      hold_data_q <= jres.data;
    end
    if (out_load) begin
      if (finish) begin
        out_data_q <= hold_vld_q ? hold_data_q : ChNul;
        out_user_q <= hold_vld_q;
        out_last_q <= 1'b1;
      end else begin
        out_data_q <= drain_q ? hold_data_q : jres.data;
        out_user_q <= 1'b1;
        out_last_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;
  assign m_axis_tlast  = out_last_q;

  // config port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LimitReset;
    end else if (psel && penable && pwrite && pready && paddr[2] == RegIdxLimit) begin
      limit_q <= pwdata[LimitW-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegIdxLimit) ? 32'(limit_q) : '0;

  a_marker_is_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tlast && m_axis_tdata == ChNul))
    else $error("empty result not marked final");

  a_hold_in_drain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_vld_q |-> drain_q)
    else $error("held result outside drain");

  a_step_head_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    jctl.step |-> cell_vld[0])
    else $error("head judged while empty");

  a_finish_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish |=> (!drain_q && !hold_vld_q && m_axis_tvalid && m_axis_tlast))
    else $error("drain end did not deliver final result");

endmodule

// ===== tb/tb_top.sv =====
// testbench for html_tag_stripper: random html documents checked against a text predictor
package hts_tb_pkg;
  import hts_pkg::*;

  localparam string ScriptOpenTag  = "<script";
  localparam string ScriptCloseTag = "</script>";
  localparam string StyleOpenTag   = "<style";
  localparam string StyleCloseTag  = "</style>";

  class text_tracker;
    typedef struct packed {
      logic [7:0] data;
      logic       has;
      logic       fin;
    } text_t;

    text_t             text_q[$];
    logic [LimitW-1:0] limit;
    logic [7:0]        win[WindowBytesDefault];
    int unsigned       fill;
    int unsigned       skip;
    bit                in_tag;
    bit                script_body;
    bit                style_body;
    bit                ended;
    logic [7:0]        prev_out;
    logic [LimitW-1:0] emitted;
    text_t             held;
    bit                have_held;
    int unsigned       fails;

    function new();
      limit = LimitReset;
      fails = 0;
      clear_doc();
    endfunction

    function void set_limit(logic [LimitW-1:0] value);
      limit = value;
    endfunction

    function int unsigned pending();
      return text_q.size();
    endfunction

    function void clear_doc();
      foreach (win[i]) win[i] = '0;
      fill        = 0;
      skip        = 0;
      in_tag      = 0;
      script_body = 0;
      style_body  = 0;
      ended       = 0;
      prev_out    = '0;
      emitted     = '0;
      have_held   = 0;
    endfunction

    function logic [7:0] lower(logic [7:0] c);
      return (c >= "A" && c <= "Z") ? (c | 8'h20) : c;
    endfunction

    function bit window_is(string pat);
      if (pat.len() > fill) return 0;
      for (int i = 0; i < pat.len(); i++) begin
        if (lower(win[i]) != pat[i]) return 0;
      end
      return 1;
    endfunction

    function bit judge(output logic [7:0] b);
      logic [7:0] c;
      c = win[0];
      b = '0;
      if (ended) return 0;
      if (skip > 0) begin
        skip--;
        return 0;
      end
      if (emitted >= limit || c == ChNul) begin
        ended = 1;
        return 0;
      end
      if (window_is(ScriptOpenTag)) begin
        script_body = 1;
        in_tag      = 1;
      end else if (window_is(ScriptCloseTag)) begin
        script_body = 0;
        in_tag      = 0;
        skip        = SkipScript;
        return 0;
      end else if (window_is(StyleOpenTag)) begin
        style_body = 1;
        in_tag     = 1;
      end else if (window_is(StyleCloseTag)) begin
        style_body = 0;
        in_tag     = 0;
        skip       = SkipStyle;
        return 0;
      end
      if (script_body || style_body) return 0;
      if (c == ChLt) begin
        in_tag = 1;
        return 0;
      end
      if (c == ChGt) begin
        in_tag = 0;
        if (emitted != 0 && prev_out != ChSpace && prev_out != ChNl) begin
          b = ChSpace;
          return 1;
        end
        return 0;
      end
      if (in_tag) return 0;
      b = c;
      return 1;
    endfunction

    function void advance();
      logic [7:0] b;
      if (judge(b)) begin
        emitted  = emitted + 1'b1;
        prev_out = b;
        if (have_held) text_q.push_back(held);
        held      = '{data: b, has: 1'b1, fin: 1'b0};
        have_held = 1;
      end
      if (fill > 0) begin
        for (int i = 0; i < WindowBytesDefault - 1; i++) win[i] = win[i+1];
        win[WindowBytesDefault-1] = '0;
        fill--;
      end
    endfunction

    function void note_byte(logic [7:0] b, logic last);
      if (!ended && fill < WindowBytesDefault) begin
        win[fill] = b;
        fill++;
      end
      if (last) begin
        while (fill > 0) advance();
        if (have_held) begin
          held.fin = 1'b1;
          text_q.push_back(held);
        end else begin
          text_q.push_back('{data: 8'h00, has: 1'b0, fin: 1'b1});
        end
        clear_doc();
      end else begin
        if (fill >= WindowBytesDefault) advance();
        if (have_held) text_q.push_back(held);
        have_held = 0;
      end
    endfunction

    task report(string msg);
      fails++;
      if (fails <= 30) $display("mismatch %0d: %s", fails, msg);
    endtask

    task check_text(logic [7:0] data, logic has, logic fin);
      text_t want;
      if (text_q.size() == 0) begin
        report($sformatf("unexpected result byte %h has %b last %b", data, has, fin));
        return;
      end
      want = text_q.pop_front();
      if (data !== want.data) report($sformatf("byte %h, want %h", data, want.data));
      if (has !== want.has) report($sformatf("has_byte %b, want %b", has, want.has));
      if (fin !== want.fin) report($sformatf("last %b, want %b", fin, want.fin));
    endtask
  endclass
endpackage

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import hts_pkg::*;
  import hts_tb_pkg::*;

  localparam logic [2:0]  RegOutputLimit = 3'd0;
  localparam int unsigned ItemTarget     = 470;
  localparam int unsigned IdleLimit      = 2000;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;  // in_byte
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;        // out_byte
  logic        m_axis_tuser;        // has_byte
  logic        m_axis_tlast;
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [2:0]  paddr         = '0;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;

  text_tracker sb = new();

  logic [7:0]  doc_q[$];
  int unsigned bytes_sent = 0;
  int unsigned burst_left = 0;
  logic [15:0] stall_pat  = 16'hFFFF;
  int unsigned pat_age    = 0;

  html_tag_stripper u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_text(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end
    if (pat_age == 0) begin
      case ($urandom_range(0, 3))
        0:       stall_pat <= 16'hFFFF;
        1:       stall_pat <= 16'($urandom & $urandom) | 16'h0001;
        default: stall_pat <= 16'($urandom) | 16'h0001;
      endcase
      pat_age <= $urandom_range(16, 80);
    end else begin
      stall_pat <= {stall_pat[0], stall_pat[15:1]};
      pat_age   <= pat_age - 1;
    end
    m_axis_tready <= stall_pat[0];
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < IdleLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("timeout: no request moved");
    $display("FAIL html_tag_stripper");
    $finish;
  end

  function automatic logic [7:0] text_byte();
    logic [7:0] c;
    case ($urandom_range(0, 9))
      0:       c = ChSpace;
      1:       c = ChNl;
      2:       c = 8'($urandom_range(128, 255));
      3:       c = 8'($urandom_range(33, 126));
      default: c = 8'($urandom_range("a", "z")) ^ ($urandom_range(0, 1) ? 8'h20 : 8'h00);
    endcase
    return c;
  endfunction

  function automatic void add_text(string s, bit mix);
    logic [7:0] c;
    for (int i = 0; i < s.len(); i++) begin
      c = s[i];
      if (mix && ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) && $urandom_range(0, 1)) begin
        c = c ^ 8'h20;
      end
      doc_q.push_back(c);
    end
  endfunction

  function automatic string pick_word(int unsigned k);
    case (k)
      0:       return "p";
      1:       return "b";
      2:       return "div";
      3:       return "br";
      4:       return "a href=x";
      5:       return "scripts";
      6:       return "sty";
      7:       return "/p";
      8:       return "</scr";
      9:       return "<scrip";
      10:      return "</style";
      default: return "<styl";
    endcase
  endfunction

  function automatic void add_body(string opener, string closer);
    add_text(opener, 1);
    if ($urandom_range(0, 2) == 0) add_text(" type=t", 0);
    add_text(">", 0);
    repeat ($urandom_range(0, 5)) begin
      case ($urandom_range(0, 3))
        0:       doc_q.push_back(ChLt);
        1:       doc_q.push_back(ChGt);
        default: doc_q.push_back(text_byte());
      endcase
    end
    if ($urandom_range(0, 5) != 0) begin
      add_text(closer, 1);
    end else begin
      add_text(closer.substr(0, closer.len() - 2), 1);
    end
  endfunction

  function automatic void build_doc();
    doc_q.delete();
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 3)) doc_q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    repeat ($urandom_range(1, 7)) begin
      case ($urandom_range(0, 9))
        0, 1, 2: repeat ($urandom_range(1, 6)) doc_q.push_back(text_byte());
        3: begin
          add_text("<", 0);
          if ($urandom_range(0, 2) == 0) add_text("/", 0);
          add_text(pick_word($urandom_range(0, 7)), 1);
          add_text(">", 0);
        end
        4:       add_body(ScriptOpenTag, ScriptCloseTag);
        5:       add_body(StyleOpenTag, StyleCloseTag);
        6:       doc_q.push_back(ChGt);
        7:       doc_q.push_back($urandom_range(0, 3) == 0 ? ChNul : 8'($urandom_range(0, 255)));
        8:       add_text(pick_word($urandom_range(8, 11)), 1);
        default: doc_q.push_back($urandom_range(0, 1) ? ChSpace : ChNl);
      endcase
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_byte(b, last);
    bytes_sent++;
  endtask

  task automatic send_doc();
    int unsigned gap;
    foreach (doc_q[i]) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(0, 3);
        if (gap != 0) begin
          s_axis_tvalid <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
        burst_left = ($urandom_range(0, 5) == 0) ? 60 : $urandom_range(1, 16);
      end
      send_byte(doc_q[i], i == doc_q.size() - 1);
      burst_left--;
    end
  endtask

  task automatic send_text(input string s);
    doc_q.delete();
    add_text(s, 0);
    send_doc();
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
    repeat (WindowBytesDefault + 4) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [LimitW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= RegOutputLimit;
    pwdata  <= 32'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_limit(value);
  endtask

  initial begin : stimulus
    int unsigned phase;
    phase = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_text("<sTyle>q</Style>A>");
    doc_q = '{8'hFF, ChNul, 8'h62};
    send_doc();
    send_text("z");
    send_text(">");

    while (bytes_sent < ItemTarget) begin
      wait_drained();
      case (phase % 7)
        0:       write_limit('0);
        1:       write_limit(LimitW'(1));
        2:       write_limit('1);
        3:       write_limit(LimitW'($urandom_range(2, 24)));
        4:       write_limit(LimitReset);
        5:       write_limit(LimitW'($urandom_range(0, 8388607)));
        default: write_limit(LimitW'($urandom_range(25, 60)));
      endcase
      repeat ($urandom_range(2, 4)) begin
        build_doc();
        send_doc();
      end
      phase++;
    end
    wait_drained();

    if (sb.fails == 0) begin
      $display("PASS html_tag_stripper");
    end else begin
      $display("FAIL html_tag_stripper");
    end
    $finish;
  end
endmodule
